// ===== rtl/slm_pkg.sv =====
// Package for the slope limiter select block: widths, fixed-point constants,
// limiter mode codes and the pipeline item type. No dependencies.
package slm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MODE_W     = 3;

  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int REM_W     = 2 * FRAC_BITS + 2;
  localparam int CMP_W     = DATA_WIDTH + FRAC_BITS + 1;
  localparam int QUO_W     = FRAC_BITS + 2;

  localparam logic [DATA_WIDTH-1:0] FX_HALF  = DATA_WIDTH'(1) << (FRAC_BITS - 1);
  localparam logic [DATA_WIDTH-1:0] FX_ONE   = DATA_WIDTH'(1) << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] FX_TWO   = DATA_WIDTH'(2) << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] FX_THREE = DATA_WIDTH'(3) << FRAC_BITS;

  localparam logic [REM_W-1:0] VL_NUM = REM_W'(1) << (2 * FRAC_BITS + 1);
  localparam logic [QUO_W-1:0] VL_TWO = QUO_W'(1) << (FRAC_BITS + 1);

  localparam logic [MODE_W-1:0] MODE_MINMOD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VANLEER  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUPERBEE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MC       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PASS     = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic                  pos;
    logic [DATA_WIDTH-1:0] simple;
    logic [DATA_WIDTH-1:0] den;
    logic [REM_W-1:0]      rem;
    logic [QUO_W-1:0]      quo;
  } slm_item_t;

endpackage

// ===== rtl/slm_front.sv =====
// First pipeline stage: evaluates minmod, superbee, MC and passthrough and
// sets up the van Leer division. Depends on slm_pkg.
module slm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  logic                           in_vld,
  input  logic [slm_pkg::DATA_WIDTH-1:0] ratio,
  input  logic [slm_pkg::MODE_W-1:0]     mode,
  output logic                           out_vld,
  output slm_pkg::slm_item_t             out_item
);
  import slm_pkg::*;

  logic                  vld_r;
  slm_item_t             item_r;
  slm_item_t             item_nxt;
  logic                  pos;
  logic [DATA_WIDTH-1:0] dbl;
  logic [DATA_WIDTH-1:0] mm;
  logic [DATA_WIDTH-1:0] sb_a;
  logic [DATA_WIDTH-1:0] sb_b;
  logic [DATA_WIDTH-1:0] sb;
  logic [DATA_WIDTH-1:0] mc_m;
  logic [DATA_WIDTH-1:0] mc_h;
  logic [DATA_WIDTH-1:0] mc;
  logic [DATA_WIDTH-1:0] res;

  always_comb begin
    pos  = !ratio[DATA_WIDTH-1] && (ratio != '0);
    dbl  = {ratio[DATA_WIDTH-2:0], 1'b0};
    mm   = (ratio < FX_ONE) ? ratio : FX_ONE;
    sb_a = (ratio >= FX_HALF) ? FX_ONE : dbl;
    sb_b = (ratio < FX_TWO) ? ratio : FX_TWO;
    sb   = (sb_a > sb_b) ? sb_a : sb_b;
    mc_m = (ratio < FX_ONE) ? dbl : FX_TWO;
    mc_h = (FX_ONE + ratio) >> 1;
    mc   = ((ratio < FX_THREE) && (mc_h < mc_m)) ? mc_h : mc_m;

    case (mode)
      MODE_SUPERBEE: res = sb;
      MODE_MC:       res = mc;
      MODE_PASS:     res = ratio;
      default:       res = mm;
    endcase
    if (!pos && (mode != MODE_PASS)) begin
      res = '0;
    end

    item_nxt.mode   = mode;
    item_nxt.pos    = pos;
    item_nxt.simple = res;
    item_nxt.den    = FX_ONE + ratio;
    item_nxt.rem    = VL_NUM;
    item_nxt.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

// ===== rtl/slm_divider.sv =====
// Restoring divider for the van Leer quotient, one quotient bit per stage.
// Depends on slm_pkg.
module slm_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               in_vld,
  input  slm_pkg::slm_item_t in_item,
  output logic               out_vld,
  output slm_pkg::slm_item_t out_item
);
  import slm_pkg::*;

  logic      vld_r  [DIV_STEPS];
  slm_item_t item_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int SH = FRAC_BITS - k;
    logic      src_vld;
    slm_item_t src;
    slm_item_t item_nxt;
    logic [CMP_W-1:0] rem_x;
    logic [CMP_W-1:0] dvs;
    logic [CMP_W-1:0] diff;

    if (k == 0) begin : g_first
      assign src_vld = in_vld;
      assign src     = in_item;
    end else begin : g_next
      assign src_vld = vld_r[k-1];
      assign src     = item_r[k-1];
    end

    always_comb begin
      rem_x    = CMP_W'(src.rem);
      dvs      = CMP_W'(src.den) << SH;
      diff     = rem_x - dvs;
      item_nxt = src;
      if (rem_x >= dvs) begin
        item_nxt.rem = diff[REM_W-1:0];
        item_nxt.quo = src.quo | (QUO_W'(1) << SH);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (advance) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        item_r[k] <= item_nxt;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STEPS-1];
  assign out_item = item_r[DIV_STEPS-1];

endmodule

// ===== rtl/slope_limiter_select.sv =====
// Top level of the slope limiter select block: mode register, front stage,
// van Leer divider pipeline and output register. Depends on slm_pkg,
// slm_front and slm_divider.
//
//   channel  ports                              direction
//   in       in_valid, in_stall, in_ratio       request in
//   out      out_valid, out_stall, out_phi      request out
//   cfg      cfg_wr_en, cfg_wr_data             mode write
//
// One request enters per cycle while in_stall is low; the pipeline is the front stage,
// one divider stage per van Leer quotient bit and the output register.
// Reset clears all valid bits and sets the mode to minmod.
// A stall on a valid output freezes the whole pipeline; in_stall follows it.
module slope_limiter_select (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [slm_pkg::DATA_WIDTH-1:0] in_ratio,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [slm_pkg::DATA_WIDTH-1:0] out_phi,
  input  logic                                  cfg_wr_en,
  input  logic [slm_pkg::MODE_W-1:0]            cfg_wr_data
);
  import slm_pkg::*;

  logic [MODE_W-1:0]     mode_r;
  logic                  advance;
  logic                  fr_vld;
  slm_item_t             fr_item;
  logic                  dv_vld;
  slm_item_t             dv_item;
  logic [QUO_W-1:0]      q_ceil;
  logic [QUO_W-1:0]      vl;
  logic [DATA_WIDTH-1:0] phi_nxt;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_phi_r;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MINMOD;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  slm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_vld   (in_valid),
    .ratio    (in_ratio),
    .mode     (mode_r),
    .out_vld  (fr_vld),
    .out_item (fr_item)
  );

  slm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_vld   (fr_vld),
    .in_item  (fr_item),
    .out_vld  (dv_vld),
    .out_item (dv_item)
  );

  always_comb begin
    q_ceil = dv_item.quo + QUO_W'(dv_item.rem != '0);
    vl     = VL_TWO - q_ceil;
    if (dv_item.mode == MODE_VANLEER) begin
      phi_nxt = dv_item.pos ? DATA_WIDTH'(vl) : '0;
    end else begin
      phi_nxt = dv_item.simple;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_phi_r <= phi_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_phi   = out_phi_r;

endmodule
